// ===== rtl/core/tcti_pkg.sv =====
package tcti_pkg;

  typedef struct packed {
    logic               func;
    logic [3:0]         param_index;
    logic signed [31:0] param_value;
    logic [7:0]         template_char;
    logic               template_last;
  } tcti_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       run_last;
    logic       template_done;
  } tcti_out_t;

  typedef enum logic [4:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR, OP_XOR,
    OP_LAND, OP_LOR, OP_EQ, OP_LT, OP_GT, OP_NOT, OP_INV,
    OP_PARAM, OP_VAR, OP_CHAR, OP_ACC
  } tcti_op_e;

  typedef enum logic [2:0] {
    SRC_CH, SRC_PCT, SRC_POP, SRC_NUM, SRC_END
  } tcti_src_e;

  localparam logic [7:0]  ChPercent = 8'h25;
  localparam logic [7:0]  ChZero    = 8'h30;
  localparam logic [7:0]  ChOne     = 8'h31;
  localparam logic [7:0]  ChLowA    = 8'h61;
  localparam logic [7:0]  ChSpace   = 8'h20;
  localparam logic [7:0]  ChMinus   = 8'h2d;
  localparam logic [7:0]  Radix     = 8'd10;
  localparam int unsigned NumVars   = 26;
  // ceil(2^35 / 10), quotient by ten is (x * recip) >> 35
  localparam logic [31:0] RecipTen  = 32'hcccccccd;
  localparam int unsigned RecipShift = 35;

  typedef struct packed {
    logic        item_ld;
    logic        param_wr;
    logic        pop;
    logic        lat_a;
    logic        lat_b;
    logic        exec;
    logic        div_start;
    logic        div_take;
    logic        push;
    logic        var_wr;
    logic        param_inc;
    logic        acc_clr;
    logic        acc_dig;
    logic        num_init;
    logic        dig_mul;
    logic        dig_step;
    logic        num_pad;
    logic        out_load;
    logic        tmpl_clr;
    logic        num_hex;
    logic        num_zero;
    logic [1:0]  num_width;
    tcti_src_e   out_src;
    tcti_op_e    op;
  } tcti_cmd_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       a_zero;
    logic       div_done;
    logic       dig_last;
    logic       num_last;
    logic       out_free;
  } tcti_status_t;

endpackage

// ===== rtl/core/tcti_dp.sv =====
module tcti_dp #(
  parameter int unsigned STACK_DEPTH = 32,
  parameter int unsigned PARAM_COUNT = 9
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tcti_pkg::tcti_in_t     in_item_i,
  input  tcti_pkg::tcti_cmd_t    cmd_i,
  output tcti_pkg::tcti_status_t st_o,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output tcti_pkg::tcti_out_t    out_item_o
);

  localparam int unsigned AddrW  = $clog2(STACK_DEPTH);
  localparam int unsigned CntW   = $clog2(STACK_DEPTH + 1);
  localparam int unsigned NumDig = 10;

  logic [7:0]  ch_q;
  logic        last_q;
  logic [31:0] params_q [PARAM_COUNT];
  logic [31:0] vars_q [tcti_pkg::NumVars];
  logic [31:0] stack_mem [STACK_DEPTH];
  logic [31:0] rdata_q;
  logic [CntW-1:0] cnt_q;
  logic        empty_q;
  logic [31:0] a_q, b_q, res_q, acc_q;
  logic [31:0] res_d;
  logic [AddrW-1:0] raddr;
  logic        can_push;

  // divider
  logic [5:0]  dcnt_q;
  logic [31:0] dquo_q, drem_q, dden_q;
  logic        dsq_q, dsa_q, dz_q;
  logic [32:0] rem_sh, diff;
  logic [31:0] div_res;

  // number formatter
  logic [31:0] mag_q;
  logic [63:0] prod_q;
  logic        neg_q, hex_q, zero_q;
  logic [1:0]  wid_q, padrem_q;
  logic [3:0]  ndig_q;
  logic [3:0]  dig_q [NumDig];
  logic [31:0] quot, dval;
  logic [3:0]  dsel, len;
  logic [7:0]  dch, num_ch;
  logic        num_last;

  logic [7:0]  pidx;
  logic [4:0]  vidx;
  logic [31:0] pval;

  tcti_pkg::tcti_out_t out_q, out_d;
  logic        out_valid_q;

  assign raddr    = AddrW'(cnt_q - 1'b1);
  assign can_push = cnt_q < CntW'(STACK_DEPTH);
  assign pidx     = ch_q - tcti_pkg::ChOne;
  assign vidx     = 5'(ch_q - tcti_pkg::ChLowA);

  always_comb begin
    pval = '0;
    for (int k = 0; k < PARAM_COUNT; k++) begin
      if (pidx == 8'(k)) pval = params_q[k];
    end
  end

  always_comb begin
    case (cmd_i.op)
      tcti_pkg::OP_ADD:   res_d = a_q + b_q;
      tcti_pkg::OP_SUB:   res_d = a_q - b_q;
      tcti_pkg::OP_MUL:   res_d = a_q * b_q;
      tcti_pkg::OP_AND:   res_d = a_q & b_q;
      tcti_pkg::OP_OR:    res_d = a_q | b_q;
      tcti_pkg::OP_XOR:   res_d = a_q ^ b_q;
      tcti_pkg::OP_LAND:  res_d = {31'b0, (a_q != '0) && (b_q != '0)};
      tcti_pkg::OP_LOR:   res_d = {31'b0, (a_q != '0) || (b_q != '0)};
      tcti_pkg::OP_EQ:    res_d = {31'b0, a_q == b_q};
      tcti_pkg::OP_LT:    res_d = {31'b0, $signed(a_q) < $signed(b_q)};
      tcti_pkg::OP_GT:    res_d = {31'b0, $signed(a_q) > $signed(b_q)};
      tcti_pkg::OP_NOT:   res_d = {31'b0, a_q == '0};
      tcti_pkg::OP_INV:   res_d = ~a_q;
      tcti_pkg::OP_PARAM: res_d = pval;
      tcti_pkg::OP_VAR:   res_d = vars_q[vidx];
      tcti_pkg::OP_CHAR:  res_d = {24'b0, ch_q};
      tcti_pkg::OP_ACC:   res_d = acc_q;
      default:            res_d = '0;
    endcase
  end

  // restoring divide on magnitudes, one quotient bit per cycle
  assign rem_sh = {drem_q, dquo_q[31]};
  assign diff   = rem_sh - {1'b0, dden_q};

  always_comb begin
    if (dz_q) begin
      div_res = '0;
    end else if (cmd_i.op == tcti_pkg::OP_DIV) begin
      div_res = dsq_q ? (32'd0 - dquo_q) : dquo_q;
    end else begin
      div_res = dsa_q ? (32'd0 - drem_q) : drem_q;
    end
  end

  // digit extraction, least significant first
  always_comb begin
    quot = hex_q ? (mag_q >> 4) : 32'(prod_q[63:tcti_pkg::RecipShift]);
    dval = hex_q ? {28'b0, mag_q[3:0]} : (mag_q - ((quot << 3) + (quot << 1)));
  end

  assign len  = ndig_q + {3'b0, neg_q};
  assign dsel = dig_q[ndig_q - 4'd1];
  assign dch  = (dsel < 4'd10) ? (tcti_pkg::ChZero + {4'b0, dsel})
                               : (tcti_pkg::ChLowA + {4'b0, dsel} - tcti_pkg::Radix);

  always_comb begin
    if (!zero_q && padrem_q != '0) begin
      num_ch = tcti_pkg::ChSpace;
    end else if (neg_q) begin
      num_ch = tcti_pkg::ChMinus;
    end else if (zero_q && padrem_q != '0) begin
      num_ch = tcti_pkg::ChZero;
    end else begin
      num_ch = dch;
    end
  end

  assign num_last = (padrem_q == '0) && !neg_q && (ndig_q == 4'd1);

  always_comb begin
    out_d.char_valid = 1'b1;
    out_d.run_last   = 1'b1;
    case (cmd_i.out_src)
      tcti_pkg::SRC_CH:  out_d.out_char = ch_q;
      tcti_pkg::SRC_PCT: out_d.out_char = tcti_pkg::ChPercent;
      tcti_pkg::SRC_POP: out_d.out_char = a_q[7:0];
      tcti_pkg::SRC_NUM: begin
        out_d.out_char = num_ch;
        out_d.run_last = num_last;
      end
      default: begin
        out_d.out_char   = '0;
        out_d.char_valid = 1'b0;
      end
    endcase
    out_d.template_done = out_d.run_last & last_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push && can_push) stack_mem[cnt_q[AddrW-1:0]] <= res_q;
    rdata_q <= stack_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.dig_mul) prod_q <= mag_q * tcti_pkg::RecipTen;
    if (cmd_i.out_load) out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q        <= '0;
      last_q      <= 1'b0;
      for (int k = 0; k < PARAM_COUNT; k++) params_q[k] <= '0;
      for (int k = 0; k < tcti_pkg::NumVars; k++) vars_q[k] <= '0;
      cnt_q       <= '0;
      empty_q     <= 1'b1;
      a_q         <= '0;
      b_q         <= '0;
      res_q       <= '0;
      acc_q       <= '0;
      dcnt_q      <= '0;
      dquo_q      <= '0;
      drem_q      <= '0;
      dden_q      <= '0;
      dsq_q       <= 1'b0;
      dsa_q       <= 1'b0;
      dz_q        <= 1'b0;
      mag_q       <= '0;
      neg_q       <= 1'b0;
      hex_q       <= 1'b0;
      zero_q      <= 1'b0;
      wid_q       <= '0;
      padrem_q    <= '0;
      ndig_q      <= '0;
      for (int k = 0; k < NumDig; k++) dig_q[k] <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.item_ld) begin
        ch_q   <= in_item_i.template_char;
        last_q <= in_item_i.template_last;
      end
      if (cmd_i.param_wr) begin
        for (int k = 0; k < PARAM_COUNT; k++) begin
          if (in_item_i.param_index == 4'(k + 1)) params_q[k] <= in_item_i.param_value;
        end
      end
      if (cmd_i.param_inc) begin
        params_q[0] <= params_q[0] + 32'd1;
        params_q[1] <= params_q[1] + 32'd1;
      end
      if (cmd_i.var_wr) vars_q[vidx] <= a_q;

      if (cmd_i.tmpl_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.pop) begin
        empty_q <= (cnt_q == '0);
        if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
      end else if (cmd_i.push && can_push) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.lat_a) a_q <= empty_q ? '0 : rdata_q;
      if (cmd_i.lat_b) b_q <= empty_q ? '0 : rdata_q;
      if (cmd_i.exec) res_q <= res_d;
      if (cmd_i.div_take) res_q <= div_res;

      if (cmd_i.tmpl_clr || cmd_i.acc_clr) begin
        acc_q <= '0;
      end else if (cmd_i.acc_dig) begin
        acc_q <= (acc_q << 3) + (acc_q << 1) + {28'b0, ch_q[3:0]};
      end

      if (cmd_i.div_start) begin
        dquo_q <= a_q[31] ? (32'd0 - a_q) : a_q;
        dden_q <= b_q[31] ? (32'd0 - b_q) : b_q;
        drem_q <= '0;
        dcnt_q <= 6'd32;
        dsq_q  <= a_q[31] ^ b_q[31];
        dsa_q  <= a_q[31];
        dz_q   <= (b_q == '0);
      end else if (dcnt_q != '0) begin
        dcnt_q <= dcnt_q - 6'd1;
        if (!diff[32]) begin
          drem_q <= diff[31:0];
          dquo_q <= {dquo_q[30:0], 1'b1};
        end else begin
          drem_q <= rem_sh[31:0];
          dquo_q <= {dquo_q[30:0], 1'b0};
        end
      end

      if (cmd_i.num_init) begin
        hex_q  <= cmd_i.num_hex;
        zero_q <= cmd_i.num_zero;
        wid_q  <= cmd_i.num_width;
        neg_q  <= !cmd_i.num_hex && a_q[31];
        mag_q  <= (!cmd_i.num_hex && a_q[31]) ? (32'd0 - a_q) : a_q;
        ndig_q <= '0;
      end else if (cmd_i.dig_step) begin
        dig_q[ndig_q] <= dval[3:0];
        ndig_q        <= ndig_q + 4'd1;
        mag_q         <= quot;
      end else if (cmd_i.num_pad) begin
        padrem_q <= ({2'b0, wid_q} > len) ? 2'({2'b0, wid_q} - len) : 2'd0;
      end else if (cmd_i.out_load && cmd_i.out_src == tcti_pkg::SRC_NUM) begin
        if (!zero_q && padrem_q != '0) begin
          padrem_q <= padrem_q - 2'd1;
        end else if (neg_q) begin
          neg_q <= 1'b0;
        end else if (zero_q && padrem_q != '0) begin
          padrem_q <= padrem_q - 2'd1;
        end else begin
          ndig_q <= ndig_q - 4'd1;
        end
      end

      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign st_o.ch       = ch_q;
  assign st_o.last     = last_q;
  assign st_o.a_zero   = (a_q == '0);
  assign st_o.div_done = (dcnt_q == '0);
  assign st_o.dig_last = (quot == '0);
  assign st_o.num_last = num_last;
  assign st_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== rtl/core/tcti_ctrl.sv =====
module tcti_ctrl #(
  parameter int unsigned NEST_LEVEL_BITS = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  tcti_pkg::tcti_in_t     in_item_i,
  output logic                   in_ready_o,
  input  tcti_pkg::tcti_status_t st_i,
  output tcti_pkg::tcti_cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_DEC, S_DISP, S_POPB, S_LATB, S_POPA, S_LATA, S_POST, S_EXEC,
    S_DIV, S_PUSH, S_DIGM, S_DIGS, S_PAD, S_NUMOUT, S_OUT1, S_FIN
  } state_e;

  typedef enum logic [3:0] {
    PH_IDLE, PH_PCT, PH_ZERO, PH_ZWID, PH_SWID, PH_PARAM, PH_SETVAR,
    PH_GETVAR, PH_CHAR, PH_CHAR_END, PH_CONST, PH_SKT, PH_SKT_PCT,
    PH_SKE, PH_SKE_PCT
  } phase_e;

  typedef enum logic [3:0] {
    ACT_NONE, ACT_PUT, ACT_PCT, ACT_NUM, ACT_PUTPOP, ACT_DISCARD, ACT_BIN,
    ACT_UN, ACT_PUSH, ACT_SETVAR, ACT_INC, ACT_TEST, ACT_ACCCLR, ACT_ACCDIG
  } act_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  act_e   act_q, act_d;
  tcti_pkg::tcti_op_e op_q, op_d;
  logic [1:0] pad_q, pad_d, fwid_q, fwid_d;
  logic       fhex_q, fhex_d, fzero_q, fzero_d, emitted_q, emitted_d;
  logic [NEST_LEVEL_BITS-1:0] skip_q, skip_d;
  logic [7:0] c;

  assign c = st_i.ch;

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    act_d     = act_q;
    op_d      = op_q;
    pad_d     = pad_q;
    fwid_d    = fwid_q;
    fhex_d    = fhex_q;
    fzero_d   = fzero_q;
    emitted_d = emitted_q;
    skip_d    = skip_q;
    cmd_o           = '0;
    cmd_o.op        = op_q;
    cmd_o.num_hex   = fhex_q;
    cmd_o.num_zero  = fzero_q;
    cmd_o.num_width = fwid_q;
    in_ready_o      = (state_q == S_IDLE);

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.item_ld = 1'b1;
          emitted_d     = 1'b0;
          if (!in_item_i.func) cmd_o.param_wr = 1'b1;
          else state_d = S_DEC;
        end
      end
      S_DEC: begin
        act_d   = ACT_NONE;
        state_d = S_DISP;
        case (phase_q)
          PH_IDLE: begin
            if (c == "%") phase_d = PH_PCT;
            else act_d = ACT_PUT;
          end
          PH_PCT: begin
            phase_d = PH_IDLE;
            case (c)
              "%": act_d = ACT_PCT;
              "d": begin
                act_d   = ACT_NUM;
                fhex_d  = 1'b0;
                fzero_d = 1'b0;
                fwid_d  = 2'd0;
              end
              "0": phase_d = PH_ZERO;
              "2", "3": begin
                pad_d   = c[1:0];
                phase_d = PH_SWID;
              end
              "c": act_d = ACT_PUTPOP;
              "s": act_d = ACT_DISCARD;
              "p": phase_d = PH_PARAM;
              "P": phase_d = PH_SETVAR;
              "g": phase_d = PH_GETVAR;
              "'": phase_d = PH_CHAR;
              "{": begin
                act_d   = ACT_ACCCLR;
                phase_d = PH_CONST;
              end
              "+": begin act_d = ACT_BIN; op_d = tcti_pkg::OP_ADD;  end
              "-": begin act_d = ACT_BIN; op_d = tcti_pkg::OP_SUB;  end
              "*": begin act_d = ACT_BIN; op_d = tcti_pkg::OP_MUL;  end
              "/": begin act_d = ACT_BIN; op_d = tcti_pkg::OP_DIV;  end
              "m": begin act_d = ACT_BIN; op_d = tcti_pkg::OP_MOD;  end
              "A": begin act_d = ACT_BIN; op_d = tcti_pkg::OP_LAND; end
              "O": begin act_d = ACT_BIN; op_d = tcti_pkg::OP_LOR;  end
              "&": begin act_d = ACT_BIN; op_d = tcti_pkg::OP_AND;  end
              "|": begin act_d = ACT_BIN; op_d = tcti_pkg::OP_OR;   end
              "^": begin act_d = ACT_BIN; op_d = tcti_pkg::OP_XOR;  end
              "=": begin act_d = ACT_BIN; op_d = tcti_pkg::OP_EQ;   end
              "<": begin act_d = ACT_BIN; op_d = tcti_pkg::OP_LT;   end
              ">": begin act_d = ACT_BIN; op_d = tcti_pkg::OP_GT;   end
              "!": begin act_d = ACT_UN;  op_d = tcti_pkg::OP_NOT;  end
              "~": begin act_d = ACT_UN;  op_d = tcti_pkg::OP_INV;  end
              "i": act_d = ACT_INC;
              "t": act_d = ACT_TEST;
              "e": begin
                skip_d  = '0;
                phase_d = PH_SKE;
              end
              default: ;
            endcase
          end
          PH_ZERO: begin
            if (c inside {"2", "3"}) begin
              pad_d   = c[1:0];
              phase_d = PH_ZWID;
            end else begin
              phase_d = PH_IDLE;
            end
          end
          PH_ZWID, PH_SWID: begin
            if (c inside {"d", "x"}) begin
              act_d   = ACT_NUM;
              fhex_d  = (c == "x");
              fzero_d = (phase_q == PH_ZWID);
              fwid_d  = pad_q;
            end
            pad_d   = 2'd0;
            phase_d = PH_IDLE;
          end
          PH_PARAM: begin
            if (c inside {["1":"9"]}) begin
              act_d = ACT_PUSH;
              op_d  = tcti_pkg::OP_PARAM;
            end
            phase_d = PH_IDLE;
          end
          PH_SETVAR: begin
            if (c inside {["a":"z"]}) act_d = ACT_SETVAR;
            phase_d = PH_IDLE;
          end
          PH_GETVAR: begin
            if (c inside {["a":"z"]}) begin
              act_d = ACT_PUSH;
              op_d  = tcti_pkg::OP_VAR;
            end
            phase_d = PH_IDLE;
          end
          PH_CHAR: begin
            act_d   = ACT_PUSH;
            op_d    = tcti_pkg::OP_CHAR;
            phase_d = PH_CHAR_END;
          end
          PH_CONST: begin
            if (c inside {["0":"9"]}) begin
              act_d = ACT_ACCDIG;
            end else begin
              act_d   = ACT_PUSH;
              op_d    = tcti_pkg::OP_ACC;
              phase_d = PH_IDLE;
            end
          end
          PH_SKT, PH_SKE: begin
            if (c == "%") phase_d = (phase_q == PH_SKT) ? PH_SKT_PCT : PH_SKE_PCT;
          end
          PH_SKT_PCT, PH_SKE_PCT: begin
            phase_d = (phase_q == PH_SKT_PCT) ? PH_SKT : PH_SKE;
            if (c == "?") begin
              if (skip_q != '1) skip_d = skip_q + 1'b1;
            end else if (c == ";") begin
              if (skip_q != '0) skip_d = skip_q - 1'b1;
              else phase_d = PH_IDLE;
            end else if (c == "e" && phase_q == PH_SKT_PCT && skip_q == '0) begin
              phase_d = PH_IDLE;
            end
          end
          default: phase_d = PH_IDLE;
        endcase
      end
      S_DISP: begin
        case (act_q)
          ACT_PUT, ACT_PCT: state_d = S_OUT1;
          ACT_BIN:          state_d = S_POPB;
          ACT_NUM, ACT_PUTPOP, ACT_DISCARD, ACT_SETVAR, ACT_TEST, ACT_UN:
                            state_d = S_POPA;
          ACT_PUSH:         state_d = S_EXEC;
          ACT_INC: begin
            cmd_o.param_inc = 1'b1;
            state_d         = S_FIN;
          end
          ACT_ACCCLR: begin
            cmd_o.acc_clr = 1'b1;
            state_d       = S_FIN;
          end
          ACT_ACCDIG: begin
            cmd_o.acc_dig = 1'b1;
            state_d       = S_FIN;
          end
          default: state_d = S_FIN;
        endcase
      end
      S_POPB: begin
        cmd_o.pop = 1'b1;
        state_d   = S_LATB;
      end
      S_LATB: begin
        cmd_o.lat_b = 1'b1;
        state_d     = S_POPA;
      end
      S_POPA: begin
        cmd_o.pop = 1'b1;
        state_d   = S_LATA;
      end
      S_LATA: begin
        cmd_o.lat_a = 1'b1;
        state_d     = S_POST;
      end
      S_POST: begin
        case (act_q)
          ACT_NUM: begin
            cmd_o.num_init = 1'b1;
            state_d        = S_DIGM;
          end
          ACT_PUTPOP: state_d = S_OUT1;
          ACT_SETVAR: begin
            cmd_o.var_wr = 1'b1;
            state_d      = S_FIN;
          end
          ACT_TEST: begin
            // false condition: skip the then part
            if (st_i.a_zero) begin
              skip_d  = '0;
              phase_d = PH_SKT;
            end
            state_d = S_FIN;
          end
          ACT_BIN, ACT_UN: state_d = S_EXEC;
          default:         state_d = S_FIN;
        endcase
      end
      S_EXEC: begin
        if (op_q == tcti_pkg::OP_DIV || op_q == tcti_pkg::OP_MOD) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          cmd_o.exec = 1'b1;
          state_d    = S_PUSH;
        end
      end
      S_DIV: begin
        if (st_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d        = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd_o.push = 1'b1;
        state_d    = S_FIN;
      end
      S_DIGM: begin
        cmd_o.dig_mul = 1'b1;
        state_d       = S_DIGS;
      end
      S_DIGS: begin
        cmd_o.dig_step = 1'b1;
        state_d        = st_i.dig_last ? S_PAD : S_DIGM;
      end
      S_PAD: begin
        cmd_o.num_pad = 1'b1;
        state_d       = S_NUMOUT;
      end
      S_NUMOUT: begin
        cmd_o.out_src = tcti_pkg::SRC_NUM;
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          emitted_d      = 1'b1;
          if (st_i.num_last) state_d = S_FIN;
        end
      end
      S_OUT1: begin
        case (act_q)
          ACT_PUT: cmd_o.out_src = tcti_pkg::SRC_CH;
          ACT_PCT: cmd_o.out_src = tcti_pkg::SRC_PCT;
          default: cmd_o.out_src = tcti_pkg::SRC_POP;
        endcase
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          emitted_d      = 1'b1;
          state_d        = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.out_src = tcti_pkg::SRC_END;
        if (!st_i.last) begin
          state_d = S_IDLE;
        end else if (emitted_q || st_i.out_free) begin
          // end marker only when the last byte gave nothing
          cmd_o.out_load = !emitted_q;
          cmd_o.tmpl_clr = 1'b1;
          phase_d        = PH_IDLE;
          pad_d          = 2'd0;
          skip_d         = '0;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      phase_q   <= PH_IDLE;
      act_q     <= ACT_NONE;
      op_q      <= tcti_pkg::OP_ADD;
      pad_q     <= '0;
      fwid_q    <= '0;
      fhex_q    <= 1'b0;
      fzero_q   <= 1'b0;
      emitted_q <= 1'b0;
      skip_q    <= '0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      act_q     <= act_d;
      op_q      <= op_d;
      pad_q     <= pad_d;
      fwid_q    <= fwid_d;
      fhex_q    <= fhex_d;
      fzero_q   <= fzero_d;
      emitted_q <= emitted_d;
      skip_q    <= skip_d;
    end
  end

endmodule

// ===== rtl/core/terminal_capability_template_interpreter.sv =====
// Expands a terminal capability template, one byte per item, into output bytes
// with a stack machine; func 0 items load parameter slots and give no result.
// One item is handled at a time. Divide and modulo use a restoring divider
// that makes one bit a cycle. Printing a number pops the value, sets up the
// formatter, makes each digit with a reciprocal multiply by ten and a
// register, works out the padding and then prints the bytes in turn; every
// result waits on the output register to be taken. Operand stack reads go
// through a memory with a registered read port.
module terminal_capability_template_interpreter #(
  parameter int unsigned STACK_DEPTH     = 32,
  parameter int unsigned PARAM_COUNT     = 9,
  parameter int unsigned NEST_LEVEL_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tcti_pkg::tcti_in_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tcti_pkg::tcti_out_t out_item_o
);

  tcti_pkg::tcti_cmd_t    cmd;
  tcti_pkg::tcti_status_t st;

  tcti_ctrl #(
    .NEST_LEVEL_BITS(NEST_LEVEL_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  tcti_dp #(
    .STACK_DEPTH(STACK_DEPTH),
    .PARAM_COUNT(PARAM_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== test/tb_terminal_capability_template_interpreter.sv =====
module tb_terminal_capability_template_interpreter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StackDepth = 32;
  localparam int unsigned ParamCount = 9;
  localparam int unsigned SkipMax = 255;
  localparam int unsigned WatchdogLimit = 20000;

  // interpreter phases
  typedef enum int {
    PH_IDLE, PH_PCT, PH_ZERO, PH_ZWID, PH_SWID, PH_PARAM, PH_SETVAR,
    PH_GETVAR, PH_CHAR, PH_CHAR_END, PH_CONST, PH_SKT, PH_SKT_PCT,
    PH_SKE, PH_SKE_PCT
  } phase_e;

  typedef enum int {FN_PARAM = 0, FN_CHAR = 1} func_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  tcti_pkg::tcti_in_t in_item_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  tcti_pkg::tcti_out_t out_item_o;

  terminal_capability_template_interpreter u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i,
    .out_valid_o, .out_ready_i, .out_item_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  logic [31:0] stk [StackDepth];
  int unsigned stk_cnt;
  logic [31:0] vars [26];
  logic [31:0] params [ParamCount];
  phase_e phase;
  int unsigned pad_w;
  logic [31:0] accum;
  int unsigned skip_lvl;
  logic [7:0] line_bytes [$];

  tcti_pkg::tcti_out_t expected_bytes [$];
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned bytes_checked;
  int unsigned idle_cycles;
  bit timed_out;

  function automatic void push_val(logic [31:0] v);
    if (stk_cnt < StackDepth) begin
      stk[stk_cnt] = v;
      stk_cnt++;
    end
  endfunction

  function automatic logic [31:0] pop_val();
    if (stk_cnt == 0) return 32'd0;
    stk_cnt--;
    return stk[stk_cnt];
  endfunction

  function automatic void print_number(logic [31:0] v, bit hex, int unsigned w, bit zpad);
    logic [7:0] digs [$];
    logic [31:0] mag;
    logic [31:0] d;
    bit neg;
    int unsigned len;
    int unsigned pad;
    mag = v;
    neg = !hex && v[31];
    if (neg) mag = -v;
    do begin
      d = hex ? (mag & 32'd15) : (mag % 32'd10);
      digs.push_front(d < 10 ? 8'h30 + d[7:0] : 8'h61 + d[7:0] - 8'd10);
      mag = hex ? (mag >> 4) : (mag / 32'd10);
    end while (mag != 0);
    len = digs.size() + (neg ? 1 : 0);
    pad = w > len ? w - len : 0;
    if (!zpad) repeat (pad) line_bytes.push_back(tcti_pkg::ChSpace);
    if (neg) line_bytes.push_back(tcti_pkg::ChMinus);
    if (zpad) repeat (pad) line_bytes.push_back(tcti_pkg::ChZero);
    foreach (digs[i]) line_bytes.push_back(digs[i]);
  endfunction

  function automatic void run_escape(logic [7:0] c);
    logic [31:0] a;
    logic [31:0] b;
    bit min_by_neg_one;
    phase = PH_IDLE;
    case (c)
      "%": line_bytes.push_back(tcti_pkg::ChPercent);
      "d": print_number(pop_val(), 1'b0, 0, 1'b0);
      "0": phase = PH_ZERO;
      "2", "3": begin
        pad_w = 32'(c - "0");
        phase = PH_SWID;
      end
      "c": begin
        a = pop_val();
        line_bytes.push_back(a[7:0]);
      end
      "s": void'(pop_val());
      "p": phase = PH_PARAM;
      "P": phase = PH_SETVAR;
      "g": phase = PH_GETVAR;
      "'": phase = PH_CHAR;
      "{": begin
        accum = '0;
        phase = PH_CONST;
      end
      "!": push_val(32'(pop_val() == 0));
      "~": push_val(~pop_val());
      "i": begin
        params[0]++;
        params[1]++;
      end
      "t": if (pop_val() == 0) begin
        skip_lvl = 0;
        phase = PH_SKT;
      end
      "e": begin
        skip_lvl = 0;
        phase = PH_SKE;
      end
      "+", "-", "*", "/", "m", "A", "O", "&", "|", "^", "=", "<", ">": begin
        b = pop_val();
        a = pop_val();
        // most negative over minus one wraps to itself
        min_by_neg_one = (a == 32'h80000000) && (b == 32'hffffffff);
        case (c)
          "+": push_val(a + b);
          "-": push_val(a - b);
          "*": push_val(a * b);
          "/": begin
            if (b == 0) push_val(32'd0);
            else if (min_by_neg_one) push_val(a);
            else push_val(32'($signed(a) / $signed(b)));
          end
          "m": begin
            if (b == 0 || min_by_neg_one) push_val(32'd0);
            else push_val(32'($signed(a) % $signed(b)));
          end
          "A": push_val(32'(a != 0 && b != 0));
          "O": push_val(32'(a != 0 || b != 0));
          "&": push_val(a & b);
          "|": push_val(a | b);
          "^": push_val(a ^ b);
          "=": push_val(32'(a == b));
          "<": push_val(32'($signed(a) < $signed(b)));
          default: push_val(32'($signed(a) > $signed(b)));
        endcase
      end
      default: ;
    endcase
  endfunction

  function automatic void interpret_byte(logic [7:0] c);
    bit then_skip;
    case (phase)
      PH_IDLE: if (c == tcti_pkg::ChPercent) phase = PH_PCT; else line_bytes.push_back(c);
      PH_PCT: run_escape(c);
      PH_ZERO: if (c == "2" || c == "3") begin
        pad_w = 32'(c - "0");
        phase = PH_ZWID;
      end else begin
        phase = PH_IDLE;
      end
      PH_ZWID, PH_SWID: begin
        if (c == "d" || c == "x") print_number(pop_val(), c == "x", pad_w, phase == PH_ZWID);
        pad_w = 0;
        phase = PH_IDLE;
      end
      PH_PARAM: begin
        if (c >= "1" && c <= "9") push_val(c - "1" < ParamCount ? params[c - "1"] : 32'd0);
        phase = PH_IDLE;
      end
      PH_SETVAR: begin
        if (c >= "a" && c <= "z") vars[c - "a"] = pop_val();
        phase = PH_IDLE;
      end
      PH_GETVAR: begin
        if (c >= "a" && c <= "z") push_val(vars[c - "a"]);
        phase = PH_IDLE;
      end
      PH_CHAR: begin
        push_val({24'd0, c});
        phase = PH_CHAR_END;
      end
      PH_CHAR_END: phase = PH_IDLE;
      PH_CONST: if (c >= "0" && c <= "9") begin
        accum = accum * 32'd10 + {24'd0, c - 8'h30};
      end else begin
        push_val(accum);
        accum = '0;
        phase = PH_IDLE;
      end
      PH_SKT, PH_SKE: if (c == tcti_pkg::ChPercent)
        phase = (phase == PH_SKT) ? PH_SKT_PCT : PH_SKE_PCT;
      default: begin
        then_skip = (phase == PH_SKT_PCT);
        phase = then_skip ? PH_SKT : PH_SKE;
        if (c == "?") begin
          if (skip_lvl < SkipMax) skip_lvl++;
        end else if (c == ";") begin
          if (skip_lvl > 0) skip_lvl--;
          else phase = PH_IDLE;
        end else if (c == "e" && then_skip && skip_lvl == 0) begin
          phase = PH_IDLE;
        end
      end
    endcase
  endfunction

  function automatic void clear_template();
    stk_cnt = 0;
    phase = PH_IDLE;
    pad_w = 0;
    accum = '0;
    skip_lvl = 0;
  endfunction

  function automatic void predict_item(tcti_pkg::tcti_in_t it);
    tcti_pkg::tcti_out_t r;
    int unsigned n;
    if (it.func == 1'(FN_PARAM)) begin
      if (it.param_index >= 1 && it.param_index <= ParamCount)
        params[it.param_index - 1] = it.param_value;
      return;
    end
    line_bytes.delete();
    interpret_byte(it.template_char);
    n = line_bytes.size();
    foreach (line_bytes[i]) begin
      r.out_char = line_bytes[i];
      r.char_valid = 1'b1;
      r.run_last = (i + 1 == n);
      r.template_done = it.template_last && (i + 1 == n);
      expected_bytes.push_back(r);
    end
    if (it.template_last) begin
      if (n == 0) begin
        r.out_char = 8'd0;
        r.char_valid = 1'b0;
        r.run_last = 1'b1;
        r.template_done = 1'b1;
        expected_bytes.push_back(r);
      end
      clear_template();
    end
  endfunction

  task automatic send_item(tcti_pkg::tcti_in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    predict_item(it);
    items_sent++;
  endtask

  task automatic load_param(int unsigned idx, logic [31:0] v);
    tcti_pkg::tcti_in_t it;
    it = '0;
    it.func = 1'(FN_PARAM);
    it.param_index = idx[3:0];
    it.param_value = v;
    it.template_char = 8'($urandom);
    it.template_last = 1'($urandom);
    send_item(it);
  endtask

  task automatic send_template(string s);
    tcti_pkg::tcti_in_t it;
    for (int i = 0; i < s.len(); i++) begin
      it = '0;
      it.func = 1'(FN_CHAR);
      it.param_index = 4'($urandom);
      it.param_value = $urandom;
      it.template_char = s[i];
      it.template_last = (i + 1 == s.len());
      send_item(it);
    end
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (expected_bytes.size() != 0 && !timed_out) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // receiver with random back-pressure
  always @(posedge clk_i) begin
    if (rst_ni) out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      bytes_checked++;
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected byte %p", out_item_o);
      end else begin
        if (out_item_o !== expected_bytes[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p actual %p", expected_bytes[0], out_item_o);
        end
        void'(expected_bytes.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchdogLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("watchdog expired, %0d bytes outstanding", expected_bytes.size());
      $display("terminal_capability_template_interpreter test failed");
      $finish;
    end
  end

  task automatic test_directed_escapes();
    load_param(1, 32'h7fffffff);
    load_param(2, 32'h80000000);
    load_param(3, 32'h80000000);
    load_param(4, 32'hffffffff);
    load_param(9, 32'hffffffff);
    load_param(0, 32'h12345678);
    load_param(15, 32'h5a5a5a5a);
    send_template("a%%%p1%d%i%p2%x%p9%03d");
    send_template("%p3%p4%/%d%p3%p4%m%d%p1%{0}%m%d%{7}%{0}%/%d");
    send_template("%{3}%{5}%<%d%s%c%A%~%x");
    send_template("%?%{0}%t1%?%{1}%tx%;%e2%;%?%{1}%t3%e4%;");
    send_template("%05d%0x%3x%2q%ppp%p0%'");
    send_template("%");
  endtask

  task automatic test_stack_limits();
    string s;
    s = "";
    for (int i = 0; i < 33; i++) s = {s, "%p1"};
    send_template({s, "%+%d"});
  endtask

  function automatic string random_escape();
    string ops;
    ops = "+-*/mAO&|^=<>!~isdc";
    case ($urandom_range(9))
      0: return $sformatf("%%p%0d", $urandom_range(1, 9));
      1: return $sformatf("%%{%0d}", $urandom_range(0, 999));
      2: return $sformatf("%%P%c", 8'($urandom_range("a", "z")));
      3: return $sformatf("%%g%c", 8'($urandom_range("a", "z")));
      4: return $sformatf("%%'%c'", 8'($urandom_range(1, 255)));
      5: return $sformatf("%%%0s%0d%c", $urandom_range(1) ? "0" : "", $urandom_range(2, 3),
                          $urandom_range(1) ? "d" : "x");
      6: return "%?%p1%t%{1}%d%e%{2}%d%;";
      7: return $sformatf("%%%c", ops[$urandom_range(ops.len() - 1)]);
      8: return $sformatf("%c", 8'($urandom));
      default: return "%d";
    endcase
  endfunction

  task automatic test_random_templates(int unsigned budget);
    string s;
    int unsigned start;
    start = items_sent;
    while (items_sent - start < budget) begin
      repeat ($urandom_range(0, 2)) load_param($urandom_range(0, 15), $urandom);
      s = "";
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 6)) s = {s, $sformatf("%c", 8'($urandom))};
      end else begin
        repeat ($urandom_range(1, 5)) s = {s, random_escape()};
      end
      send_template(s);
    end
  endtask

  initial begin
    send_idle_pct = 7;
    recv_idle_pct = 64;
    stk_cnt = 0;
    foreach (vars[i]) vars[i] = '0;
    foreach (params[i]) params[i] = '0;
    clear_template();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_escapes();
    test_stack_limits();
    test_random_templates(8);
    send_idle_pct = 64;
    recv_idle_pct = 7;
    test_random_templates(8);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_templates(8);
    wait_drain();
    $display("sent %0d items, checked %0d output bytes, %0d mismatches",
             items_sent, bytes_checked, mismatches);
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("terminal_capability_template_interpreter test passed");
    end else begin
      $display("terminal_capability_template_interpreter test failed");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/core/tcti_pkg.sv
rtl/core/tcti_dp.sv
rtl/core/tcti_ctrl.sv
rtl/core/terminal_capability_template_interpreter.sv
test/tb_terminal_capability_template_interpreter.sv
